// ===== hdl/gwsp_pkg.sv =====
package gwsp_pkg;

   // Parser phase
   typedef enum logic [1:0] {
      PH_LETTER,
      PH_SIGN0,
      PH_SIGN1,
      PH_NUMBER
   } phase_type;

   // Result kind
   typedef enum logic [2:0] {
      KIND_VALUE,
      KIND_MODAL_G,
      KIND_STORED_G,
      KIND_M_WORD,
      KIND_UNSUPPORTED_G,
      KIND_UNKNOWN
   } kind_type;

   // Word codes
   localparam logic [3:0] CODE_A = 4'd0;
   localparam logic [3:0] CODE_B = 4'd1;
   localparam logic [3:0] CODE_C = 4'd2;
   localparam logic [3:0] CODE_F = 4'd3;
   localparam logic [3:0] CODE_G = 4'd4;
   localparam logic [3:0] CODE_M = 4'd5;
   localparam logic [3:0] CODE_N = 4'd6;
   localparam logic [3:0] CODE_P = 4'd7;
   localparam logic [3:0] CODE_S = 4'd8;
   localparam logic [3:0] CODE_X = 4'd9;
   localparam logic [3:0] CODE_Y = 4'd10;
   localparam logic [3:0] CODE_Z = 4'd11;

   localparam int WORD_COUNT = 12;

   // Characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOWER = 8'h20;

   // G numbers with a meaning
   localparam logic [6:0] G_RAPID    = 7'd0;
   localparam logic [6:0] G_LINEAR   = 7'd1;
   localparam logic [6:0] G_DWELL    = 7'd4;
   localparam logic [6:0] G_INCH     = 7'd20;
   localparam logic [6:0] G_MM       = 7'd21;
   localparam logic [6:0] G_HOME     = 7'd28;
   localparam logic [6:0] G_ABSOLUTE = 7'd90;
   localparam logic [6:0] G_INCREMENTAL = 7'd91;
   localparam logic [6:0] G_SET_POS  = 7'd92;

   // One result word
   typedef struct packed {
      logic                  last;
      logic [WORD_COUNT-1:0] words_mask;
      logic                  axis_cmd_seen;
      logic                  distance_incremental;
      logic                  metric_units;
      logic                  feed_linear;
      logic [6:0]            g_number;
      logic [31:0]           value;
      logic [3:0]            word_code;
      kind_type              kind;
   } result_type;

   // Powers of ten up to one million
   function automatic logic [19:0] pow10_of(input logic [2:0] n);
      logic [19:0] p;
      case (n)
         3'd0:    p = 20'd1;
         3'd1:    p = 20'd10;
         3'd2:    p = 20'd100;
         3'd3:    p = 20'd1000;
         3'd4:    p = 20'd10000;
         3'd5:    p = 20'd100000;
         3'd6:    p = 20'd1000000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

   // Map a letter of either case to {known, word code}
   function automatic logic [4:0] letter_code(input logic [7:0] c);
      logic [4:0] r;
      case (c | CH_LOWER)
         "a":     r = {1'b1, CODE_A};
         "b":     r = {1'b1, CODE_B};
         "c":     r = {1'b1, CODE_C};
         "f":     r = {1'b1, CODE_F};
         "g":     r = {1'b1, CODE_G};
         "m":     r = {1'b1, CODE_M};
         "n":     r = {1'b1, CODE_N};
         "p":     r = {1'b1, CODE_P};
         "s":     r = {1'b1, CODE_S};
         "x":     r = {1'b1, CODE_X};
         "y":     r = {1'b1, CODE_Y};
         "z":     r = {1'b1, CODE_Z};
         default: r = {1'b0, CODE_A};
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/gcode_word_stream_parser.sv =====
// An accepted character sits in the input register, then its result words enter the queue.
// Throughput: one character per cycle while the queue has room. A character that ends a word
// and is also an unknown letter pushes two result words, and the result port drains at most
// one per cycle, so a four-word queue absorbs bursts; the input waits unless two slots are
// free, or one is free and a word is being popped.
// Synchronous active-high reset: expect a word letter, clear modal state, flags and queue.
module gcode_word_stream_parser
   import gwsp_pkg::*;
#(
   parameter int FRACTION_DIGITS = 4,
   parameter int VALUE_WIDTH     = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Character channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_block
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] word_code, [35:4] value, [42:36] g_number, [43] feed_linear,
   // [44] metric_units, [45] distance_incremental, [46] axis_cmd_seen,
   // [58:47] words_mask, [63:59] zero
   output logic [63:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last
);

   // Magnitude width, and a sum width wide enough for acc*10 + 9*10^6
   localparam int MW = VALUE_WIDTH - 1;
   localparam int SW = VALUE_WIDTH + 24;
   localparam logic [2:0]    FD3    = 3'(FRACTION_DIGITS);
   localparam logic [MW-1:0] MAXMAG = '1;
   localparam logic [SW-1:0] POW_FD = SW'(pow10_of(FD3));
   // Integer part of a saturated magnitude
   localparam logic [SW-1:0] SAT_IP = SW'(MAXMAG) / POW_FD;
   localparam logic          SAT_IP_BIG = (SAT_IP >= SW'(128));
   localparam logic [6:0]    SAT_IP7 = SAT_IP[6:0];

   localparam int QDEPTH = 4;
   localparam int QPW    = $clog2(QDEPTH);

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_eob_ff;
   logic       fire;

   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload: load on every accepted character
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff  <= req_tdata;
         in_eob_ff <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // Parser state
   // ------------------------------------------------------------------
   phase_type             phase_ff, phase_in;
   logic [3:0]            pending_ff, pending_in;
   logic [MW-1:0]         acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [2:0]            fd_ff, fd_in;
   // Integer part of the number, tracked alongside the magnitude
   logic [6:0]            ip_ff, ip_in;
   logic                  ip_big_ff, ip_big_in;
   logic                  motion_ff, motion_in;
   logic                  units_ff, units_in;
   logic                  dist_ff, dist_in;
   logic [WORD_COUNT-1:0] mask_ff, mask_in;
   logic                  axis_ff, axis_in;
   logic [6:0]            gnum_ff, gnum_in;

   // ------------------------------------------------------------------
   // Character decode
   // ------------------------------------------------------------------
   logic       in_number, is_digit, lc_known;
   logic [3:0] digit, lc_code;
   logic [4:0] lc_word;
   logic       take_plus, take_minus, take_digit, take_point;
   logic       at_letter, do_finish, new_word, unknown;

   assign lc_word   = letter_code(in_ch_ff);
   assign lc_known  = lc_word[4];
   assign lc_code   = lc_word[3:0];
   assign digit     = 4'(in_ch_ff - CH_ZERO);
   assign is_digit  = (in_ch_ff >= CH_ZERO) && (in_ch_ff <= CH_NINE);
   assign in_number = (phase_ff != PH_LETTER);

   assign take_plus  = !in_eob_ff && (phase_ff == PH_SIGN0) && (in_ch_ff == CH_PLUS);
   assign take_minus = !in_eob_ff && ((phase_ff == PH_SIGN0) || (phase_ff == PH_SIGN1))
                       && (in_ch_ff == CH_MINUS);
   assign take_digit = !in_eob_ff && in_number && is_digit;
   assign take_point = !in_eob_ff && in_number && (in_ch_ff == CH_POINT) && (fd_ff == 3'd0);

   // Character falls through to word letter handling
   assign at_letter = !in_eob_ff && !(take_plus || take_minus || take_digit || take_point);
   // Any character that cannot continue the number closes the pending word
   assign do_finish = in_number && (in_eob_ff || at_letter);
   assign new_word  = at_letter && lc_known;
   assign unknown   = at_letter && !lc_known && (in_ch_ff != CH_SPACE);

   // ------------------------------------------------------------------
   // Number accumulation
   // ------------------------------------------------------------------
   logic [SW-1:0] acc_x10, int_sum, frac_sum, step_sum;
   logic          step_sat, frac_live;
   logic [10:0]   ip_x10;

   assign acc_x10   = (SW'(acc_ff) << 3) + (SW'(acc_ff) << 1);
   assign int_sum   = acc_x10 + SW'(digit) * POW_FD;
   assign frac_sum  = SW'(acc_ff) + SW'(digit) * SW'(pow10_of(FD3 - fd_ff));
   assign frac_live = (fd_ff != 3'd0) && (fd_ff <= FD3);
   assign step_sum  = (fd_ff == 3'd0) ? int_sum : frac_sum;
   assign step_sat  = step_sum > SW'(MAXMAG);
   assign ip_x10    = (11'(ip_ff) << 3) + (11'(ip_ff) << 1) + 11'(digit);

   // ------------------------------------------------------------------
   // Word completion
   // ------------------------------------------------------------------
   kind_type                  fin_kind;
   logic                      motion_mid, units_mid, dist_mid, axis_mid;
   logic [6:0]                gnum_mid;
   logic [WORD_COUNT-1:0]     mask_mid;
   logic signed [VALUE_WIDTH-1:0] sval;
   logic [31:0]               val32;

   assign sval  = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
   assign val32 = 32'(sval);

   // Status after the completed word has taken effect
   always_comb begin
      fin_kind   = KIND_VALUE;
      motion_mid = motion_ff;
      units_mid  = units_ff;
      dist_mid   = dist_ff;
      axis_mid   = axis_ff;
      gnum_mid   = gnum_ff;
      mask_mid   = mask_ff;
      if (pending_ff == CODE_G) begin
         fin_kind = KIND_UNSUPPORTED_G;
         if (ip_big_ff || (neg_ff && (ip_ff != 7'd0))) begin
            fin_kind = KIND_UNSUPPORTED_G;
         end else begin
            case (ip_ff)
               G_RAPID, G_LINEAR: begin
                  fin_kind   = KIND_MODAL_G;
                  motion_mid = (ip_ff == G_LINEAR);
               end
               G_INCH, G_MM: begin
                  fin_kind  = KIND_MODAL_G;
                  units_mid = (ip_ff == G_MM);
               end
               G_ABSOLUTE, G_INCREMENTAL: begin
                  fin_kind = KIND_MODAL_G;
                  dist_mid = (ip_ff == G_INCREMENTAL);
               end
               G_DWELL: begin
                  fin_kind = KIND_STORED_G;
                  gnum_mid = ip_ff;
               end
               G_HOME, G_SET_POS: begin
                  fin_kind = KIND_STORED_G;
                  gnum_mid = ip_ff;
                  axis_mid = 1'b1;
               end
               default: begin
                  fin_kind = KIND_UNSUPPORTED_G;
               end
            endcase
         end
      end else if (pending_ff == CODE_M) begin
         fin_kind = KIND_M_WORD;
      end else begin
         mask_mid = mask_ff | (WORD_COUNT'(1) << pending_ff);
      end
      if (!do_finish) begin
         fin_kind   = KIND_VALUE;
         motion_mid = motion_ff;
         units_mid  = units_ff;
         dist_mid   = dist_ff;
         axis_mid   = axis_ff;
         gnum_mid   = gnum_ff;
         mask_mid   = mask_ff;
      end
   end

   // ------------------------------------------------------------------
   // Next phase
   // ------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (in_eob_ff) begin
            phase_in = PH_LETTER;
         end else if (take_plus) begin
            phase_in = PH_SIGN1;
         end else if (take_minus || take_digit || take_point) begin
            phase_in = PH_NUMBER;
         end else if (new_word) begin
            phase_in = PH_SIGN0;
         end else begin
            phase_in = PH_LETTER;
         end
      end
   end

   // ------------------------------------------------------------------
   // Next datapath state
   // ------------------------------------------------------------------
   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      fd_in      = fd_ff;
      ip_in      = ip_ff;
      ip_big_in  = ip_big_ff;
      motion_in  = motion_ff;
      units_in   = units_ff;
      dist_in    = dist_ff;
      mask_in    = mask_ff;
      axis_in    = axis_ff;
      gnum_in    = gnum_ff;
      if (fire) begin
         motion_in = motion_mid;
         units_in  = units_mid;
         dist_in   = dist_mid;
         gnum_in   = gnum_mid;
         // Clear block flags at the terminator, after the last word reports them
         mask_in   = in_eob_ff ? '0 : mask_mid;
         axis_in   = in_eob_ff ? 1'b0 : axis_mid;
         if (take_minus) begin
            neg_in = 1'b1;
         end
         if (take_point) begin
            fd_in = 3'd1;
         end
         if (take_digit && ((fd_ff == 3'd0) || frac_live)) begin
            if (frac_live) begin
               fd_in = fd_ff + 3'd1;
            end
            if (step_sat) begin
               acc_in    = MAXMAG;
               ip_in     = SAT_IP7;
               ip_big_in = SAT_IP_BIG;
            end else begin
               acc_in = step_sum[MW-1:0];
               if (fd_ff == 3'd0) begin
                  ip_in     = ip_x10[6:0];
                  ip_big_in = ip_big_ff || (ip_x10 >= 11'd128);
               end
            end
         end
         if (new_word) begin
            pending_in = lc_code;
            acc_in     = '0;
            neg_in     = 1'b0;
            fd_in      = 3'd0;
            ip_in      = 7'd0;
            ip_big_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LETTER;
         pending_ff <= '0;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         fd_ff      <= 3'd0;
         ip_ff      <= 7'd0;
         ip_big_ff  <= 1'b0;
         motion_ff  <= 1'b0;
         units_ff   <= 1'b0;
         dist_ff    <= 1'b0;
         mask_ff    <= '0;
         axis_ff    <= 1'b0;
         gnum_ff    <= 7'd0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         fd_ff      <= fd_in;
         ip_ff      <= ip_in;
         ip_big_ff  <= ip_big_in;
         motion_ff  <= motion_in;
         units_ff   <= units_in;
         dist_ff    <= dist_in;
         mask_ff    <= mask_in;
         axis_ff    <= axis_in;
         gnum_ff    <= gnum_in;
      end
   end

   // ------------------------------------------------------------------
   // Result words for this character
   // ------------------------------------------------------------------
   result_type fin_word, unk_word, push0, push1;
   logic       push0_v, push1_v;

   always_comb begin
      fin_word.kind                 = fin_kind;
      fin_word.word_code            = pending_ff;
      fin_word.value                = val32;
      fin_word.g_number             = gnum_mid;
      fin_word.feed_linear          = motion_mid;
      fin_word.metric_units         = units_mid;
      fin_word.distance_incremental = dist_mid;
      fin_word.axis_cmd_seen        = axis_mid;
      fin_word.words_mask           = mask_mid;
      fin_word.last                 = !unknown;

      unk_word          = fin_word;
      unk_word.kind      = KIND_UNKNOWN;
      unk_word.word_code = CODE_A;
      unk_word.value     = 32'd0;
      unk_word.last      = 1'b1;
   end

   assign push0_v = fire && (do_finish || unknown);
   assign push1_v = fire && do_finish && unknown;
   assign push0   = do_finish ? fin_word : unk_word;
   assign push1   = unk_word;

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   result_type q_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]   cnt_ff, cnt_in;
   logic           pop;
   logic [1:0]     push_n;
   result_type     head;

   assign pop    = rsp_tvalid && rsp_tready;
   assign push_n = {1'b0, push0_v} + {1'b0, push1_v};
   // Process a character only when both of its possible words fit
   assign fire   = in_valid_ff
                   && ((cnt_ff <= (QPW+1)'(QDEPTH - 2))
                       || ((cnt_ff == (QPW+1)'(QDEPTH - 1)) && pop));

   assign wr_ptr_in = wr_ptr_ff + QPW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPW'(pop);
   assign cnt_in    = cnt_ff + (QPW+1)'(push_n) - (QPW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0_v) begin
         q_ff[wr_ptr_ff] <= push0;
      end
      if (push1_v) begin
         q_ff[wr_ptr_ff + QPW'(1)] <= push1;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {5'd0, head.words_mask, head.axis_cmd_seen,
                        head.distance_incremental, head.metric_units, head.feed_linear,
                        head.g_number, head.value, head.word_code};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPW+1)'(QDEPTH))
      else $error("result queue overfilled");

   a_eob_resets_phase: assert property (@(posedge clock) disable iff (reset)
      fire && in_eob_ff |=> phase_ff == PH_LETTER && mask_ff == '0 && !axis_ff)
      else $error("terminator left block state behind");

   a_unknown_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_UNKNOWN) |-> rsp_tdata[35:0] == 36'd0 && rsp_tlast)
      else $error("unknown letter word carries a value");

   a_fraction_bound: assert property (@(posedge clock) disable iff (reset)
      fd_ff <= FD3 + 3'd1)
      else $error("fraction digit count out of range");

   a_accepted_gets_done: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire && (cnt_ff == '0) |-> 1'b0)
      else $error("parse stage stalled with an empty queue");

endmodule
